/* sv/tgr_pkg.sv */
package tgr_pkg;
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_REL  = 2'd1,
        PH_WAIT_DBL  = 2'd2,
        PH_WAIT_SLIDE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        G_CLICK  = 2'd0,
        G_DOUBLE = 2'd1,
        G_SLIDE  = 2'd2
    } gesture_t;

    typedef enum logic [1:0] {
        REG_SIM    = 2'd0,
        REG_CLICK  = 2'd1,
        REG_DBL    = 2'd2,
        REG_JITTER = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_EVAL,
        C_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic eval;      // apply the captured item to the state
        logic emit_step; // advance output queue after a handoff
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_out;   // queue holds a pending result
    } dp_stat_t;
endpackage

/* sv/tgr_ctrl.sv */
module tgr_ctrl
    import tgr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     out_fire,
    input  dp_stat_t stat,
    output logic     in_ready,
    output logic     out_valid,
    output dp_cmd_t  cmd
);
    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (in_fire) state_next = C_EVAL;
            C_EVAL: state_next = C_EMIT;
            C_EMIT: if (!stat.has_out) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = (state_reg == C_IDLE);
        out_valid     = (state_reg == C_EMIT) && stat.has_out;
        cmd.eval      = (state_reg == C_EVAL);
        cmd.emit_step = out_fire;
    end
endmodule

/* sv/tgr_datapath.sv */
module tgr_datapath
    import tgr_pkg::*;
#(
    parameter int CHANNELS  = 12,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [1:0]  in_op,
    input  logic [3:0]  in_channel,
    input  logic [31:0] in_event_ms,
    input  logic [31:0] in_now_ms,
    input  logic        cfg_fire,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [1:0]  out_gesture,
    output logic [3:0]  out_channel,
    output logic        out_last
);
    localparam int TB = TIME_BITS;
    localparam int NB = $clog2(CHANNELS + 1);
    localparam int TW = (TB > 32) ? TB : 32;

    typedef logic [TB-1:0] tm_t;

    logic [15:0] sim_reg, clk_reg, dbl_reg, jit_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  latest_reg, latest_next, main_reg, main_next;
    logic [1:0]  tally_reg, tally_next;
    logic [3:0]  held_reg [CHANNELS];
    logic [3:0]  held_next [CHANNELS];
    logic [NB-1:0] hcnt_reg, hcnt_next;
    logic [3:0]  path_reg [CHANNELS];
    logic [3:0]  path_next [CHANNELS];
    logic [NB-1:0] plen_reg, plen_next;
    tm_t         fps_reg, fps_next, pst_reg, pst_next, rel_reg, rel_next, acc_reg, acc_next;
    logic [4:0]  pch_reg, pch_next;
    logic [1:0]  pop_reg, pop_next;

    logic [1:0]  op_reg;
    logic [3:0]  ch_reg;
    tm_t         ev_reg, now_reg;

    // output queue
    logic [1:0]  qg_reg [CHANNELS];
    logic [1:0]  qg_next [CHANNELS];
    logic [3:0]  qc_reg [CHANNELS];
    logic [3:0]  qc_next [CHANNELS];
    logic [NB-1:0] qn_reg, qn_next, qi_reg, qi_next;

    function automatic tm_t mag(tm_t d);
        return d[TB-1] ? tm_t'(-d) : d;
    endfunction

    logic [TW-1:0] ev_w, now_w;
    assign ev_w  = TW'(in_event_ms);
    assign now_w = TW'(in_now_ms);

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg  <= in_op;
            ch_reg  <= in_channel;
            ev_reg  <= ev_w[TB-1:0];
            now_reg <= now_w[TB-1:0];
        end
    end

    logic is_held;
    logic [NB-1:0] kept;
    logic [3:0] comp [CHANNELS];
    logic jit_pass;
    tm_t d_now_acc, d_now_rel, d_now_pst, d_ev_fps;

    always_comb begin
        is_held = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
            if (NB'(i) < hcnt_reg && held_reg[i] == ch_reg) is_held = 1'b1;
        kept = '0;
        for (int i = 0; i < CHANNELS; i++) comp[i] = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (NB'(i) < hcnt_reg && held_reg[i] != ch_reg) begin
                comp[kept[$clog2(CHANNELS)-1:0]] = held_reg[i];
                kept = kept + 1'b1;
            end
        end
    end

    always_comb begin
        d_now_acc = now_reg - acc_reg;
        d_now_rel = now_reg - rel_reg;
        d_now_pst = now_reg - pst_reg;
        d_ev_fps  = mag(ev_reg - fps_reg);
        jit_pass  = (d_now_acc > tm_t'(jit_reg)) || ({1'b0, ch_reg} != pch_reg)
                    || (op_reg != pop_reg);
    end

    always_comb begin
        logic do_reset;
        logic [NB-1:0] k;
        phase_next  = phase_reg;
        latest_next = latest_reg;
        main_next   = main_reg;
        tally_next  = tally_reg;
        held_next   = held_reg;
        hcnt_next   = hcnt_reg;
        path_next   = path_reg;
        plen_next   = plen_reg;
        fps_next    = fps_reg;
        pst_next    = pst_reg;
        rel_next    = rel_reg;
        acc_next    = acc_reg;
        pch_next    = pch_reg;
        pop_next    = pop_reg;
        qg_next     = qg_reg;
        qc_next     = qc_reg;
        qn_next     = qn_reg;
        qi_next     = qi_reg;
        do_reset    = 1'b0;
        k = '0;
        if (cmd.eval) begin
            qn_next = '0;
            qi_next = '0;
            if (op_reg == OP_TICK) begin
                if (phase_reg == PH_WAIT_DBL && d_now_rel > tm_t'(dbl_reg)) begin
                    qg_next[0] = G_CLICK; qc_next[0] = main_reg; qn_next = NB'(1);
                    do_reset = 1'b1;
                end
            end else if (op_reg != OP_NONE && jit_pass) begin
                acc_next = now_reg;
                pch_next = {1'b0, ch_reg};
                pop_next = op_reg;
                if ({1'b0, ch_reg} < 5'(CHANNELS)) begin
                    unique case (phase_reg)
                        PH_IDLE: if (op_reg == OP_PRESS) begin
                            latest_next = ch_reg; held_next[0] = ch_reg; hcnt_next = NB'(1);
                            fps_next = ev_reg; pst_next = now_reg; phase_next = PH_WAIT_REL;
                        end
                        PH_WAIT_REL: begin
                            if (op_reg == OP_PRESS) begin
                                if (d_ev_fps > tm_t'(sim_reg)) begin
                                    path_next[0] = latest_reg; path_next[1] = ch_reg;
                                    plen_next = NB'(2); main_next = latest_reg;
                                    latest_next = ch_reg; phase_next = PH_WAIT_SLIDE;
                                end
                                if (!is_held && hcnt_reg < NB'(CHANNELS)) begin
                                    held_next[hcnt_reg[$clog2(CHANNELS)-1:0]] = ch_reg;
                                    hcnt_next = hcnt_reg + 1'b1;
                                end
                            end else if (is_held) begin
                                held_next = comp; hcnt_next = kept;
                                if (kept == '0) begin
                                    if (d_now_pst > tm_t'(clk_reg)) do_reset = 1'b1;
                                    else begin
                                        rel_next = now_reg; tally_next = tally_reg + 1'b1;
                                        main_next = latest_reg; phase_next = PH_WAIT_DBL;
                                    end
                                end
                            end
                        end
                        PH_WAIT_DBL: begin
                            if (d_now_rel > tm_t'(dbl_reg)) begin
                                qg_next[0] = G_CLICK; qc_next[0] = main_reg; qn_next = NB'(1);
                                do_reset = 1'b1;
                            end else if (op_reg == OP_PRESS) begin
                                latest_next = ch_reg; held_next[0] = ch_reg;
                                hcnt_next = NB'(1); fps_next = ev_reg; pst_next = now_reg;
                                phase_next = PH_WAIT_REL;
                            end
                        end
                        default: begin
                            if (op_reg == OP_PRESS) begin
                                if (d_ev_fps > tm_t'(sim_reg) && !is_held) begin
                                    if (plen_reg < NB'(CHANNELS)) begin
                                        path_next[plen_reg[$clog2(CHANNELS)-1:0]] = ch_reg;
                                        plen_next = plen_reg + 1'b1;
                                        latest_next = ch_reg;
                                    end
                                    if (hcnt_reg < NB'(CHANNELS)) begin
                                        held_next[hcnt_reg[$clog2(CHANNELS)-1:0]] = ch_reg;
                                        hcnt_next = hcnt_reg + 1'b1;
                                    end
                                end
                            end else if (is_held) begin
                                held_next = comp; hcnt_next = kept;
                                if (kept == '0) begin
                                    if (plen_reg >= NB'(2)) begin
                                        for (int i = 0; i < CHANNELS; i++) begin
                                            qg_next[i] = G_SLIDE; qc_next[i] = path_reg[i];
                                        end
                                        qn_next = plen_reg;
                                    end
                                    do_reset = 1'b1;
                                end
                            end
                        end
                    endcase
                    // double click check uses post-update tally and release time
                    if (!do_reset && tally_next == 2'd2 && (now_reg - rel_next) <= tm_t'(dbl_reg)) begin
                        k = qn_next;
                        qg_next[k[$clog2(CHANNELS)-1:0]] = G_DOUBLE;
                        qc_next[k[$clog2(CHANNELS)-1:0]] = main_next;
                        qn_next = k + 1'b1;
                        do_reset = 1'b1;
                    end
                end
            end
            if (do_reset) begin
                phase_next = PH_IDLE; latest_next = '0; main_next = '0; tally_next = '0;
                hcnt_next = '0; plen_next = '0;
                for (int i = 0; i < CHANNELS; i++) begin
                    held_next[i] = '0; path_next[i] = '0;
                end
            end
        end else if (cmd.emit_step) begin
            qi_next = qi_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sim_reg <= 16'd50; clk_reg <= 16'd500; dbl_reg <= 16'd600; jit_reg <= 16'd30;
            phase_reg <= PH_IDLE; latest_reg <= '0; main_reg <= '0; tally_reg <= '0;
            hcnt_reg <= '0; plen_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                held_reg[i] <= '0; path_reg[i] <= '0;
            end
            fps_reg <= '0; pst_reg <= '0; rel_reg <= '0; acc_reg <= '0;
            pch_reg <= 5'd16; pop_reg <= OP_NONE;
            qn_reg <= '0; qi_reg <= '0;
        end else begin
            if (cfg_fire) begin
                unique case (reg_idx_t'(cfg_index))
                    REG_SIM:    sim_reg <= cfg_data;
                    REG_CLICK:  clk_reg <= cfg_data;
                    REG_DBL:    dbl_reg <= cfg_data;
                    REG_JITTER: jit_reg <= cfg_data;
                    default: ;
                endcase
            end
            phase_reg <= phase_next; latest_reg <= latest_next; main_reg <= main_next;
            tally_reg <= tally_next; held_reg <= held_next; hcnt_reg <= hcnt_next;
            path_reg <= path_next; plen_reg <= plen_next;
            fps_reg <= fps_next; pst_reg <= pst_next; rel_reg <= rel_next; acc_reg <= acc_next;
            pch_reg <= pch_next; pop_reg <= pop_next;
            qn_reg <= qn_next; qi_reg <= qi_next;
        end
    end

    always_ff @(posedge aclk) begin
        qg_reg <= qg_next;
        qc_reg <= qc_next;
    end

    logic [$clog2(CHANNELS)-1:0] qsel;
    assign qsel        = qi_reg[$clog2(CHANNELS)-1:0];
    assign stat.has_out = (qi_reg < qn_reg);
    assign out_gesture = qg_reg[qsel];
    assign out_channel = qc_reg[qsel];
    assign out_last    = (qi_reg + 1'b1 == qn_reg);
endmodule

/* sv/touch_gesture_recognizer.sv */
// timing: an item is evaluated in the cycle after acceptance; its first result is
// offered in the cycle after that, then results stream one per cycle while m_tready
// is high, last one marked by m_tlast
// input: a new item is not accepted until every result of the previous one has drained
// (the list scan is a combinational parallel compare; the queue drains serially)
// reset: aresetn synchronous active low; registers return to defaults, gesture idle
module touch_gesture_recognizer
    import tgr_pkg::*;
#(
    parameter int CHANNELS  = 12,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // channel[3:0], event_ms[35:4], now_ms[67:36], zero pad
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // gesture_channel[3:0], zero pad
    output logic [1:0]  m_tuser,   // gesture
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic in_fire, out_fire;
    logic [3:0] gch;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // sequencer: capture, evaluate, drain results
    tgr_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .out_fire, .stat,
        .in_ready(s_tready), .out_valid(m_tvalid), .cmd
    );

    // state, lists and result queue
    tgr_datapath #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_dp (
        .aclk, .aresetn, .in_fire,
        .in_op(s_tuser), .in_channel(s_tdata[3:0]),
        .in_event_ms(s_tdata[35:4]), .in_now_ms(s_tdata[67:36]),
        .cfg_fire(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
        .cmd, .stat, .out_gesture(m_tuser), .out_channel(gch), .out_last(m_tlast)
    );

    assign m_tdata = {4'b0, gch};

    // no new transaction while results are pending
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while draining");
    // tlast only rides on a valid result
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tlast |-> m_tvalid) else $error("tlast without tvalid");
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready) else $error("ready right after accept");
endmodule
